[sv/ius_pkg.sv]
// ============================================================================
// ius_pkg - shared types and constants of the integer upscale pixel writer
// Holds the configuration record, the job and write records passed between
// pipeline stages, register map codes and picture dimensions.
// ============================================================================
`default_nettype none

package ius_pkg;

    // Source picture size and largest replication factor.
    localparam int SRC_WIDTH  = 160;
    localparam int SRC_HEIGHT = 144;
    localparam int MAX_SCALE  = 8;

    // Field widths fixed by the interface.
    localparam int COL_W    = 8;
    localparam int ROW_W    = 8;
    localparam int COLOR_W  = 32;
    localparam int OFFSET_W = 26;
    localparam int DIM_W    = 12;
    localparam int STRIDE_W = 14;
    localparam int SCALE_W  = 4;
    localparam int DATA_W   = 32;

    // Derived widths.
    localparam int CNT_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int NUM_W  = $clog2(MAX_SCALE + 1);
    localparam int BASE_W = DIM_W + 1;
    localparam int XOFF_W = DIM_W + 2;

    // RGB565 packing masks.
    localparam logic [15:0] MASK_RED   = 16'hF800;
    localparam logic [15:0] MASK_GREEN = 16'h07E0;
    localparam logic [15:0] MASK_BLUE  = 16'h001F;

    // Register map: register i sits at byte address 4*i.
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_STRIDE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIDE_PIXELS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_OFFSET  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TOP_OFFSET   = 3'd6;

    // Register reset values.
    localparam logic [DIM_W-1:0]    RST_PANEL_WIDTH  = 12'd160;
    localparam logic [DIM_W-1:0]    RST_PANEL_HEIGHT = 12'd144;
    localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE  = 14'd640;
    localparam logic                RST_WIDE_PIXELS  = 1'b1;
    localparam logic [SCALE_W-1:0]  RST_SCALE_FACTOR = 4'd1;
    localparam logic [DIM_W-1:0]    RST_LEFT_OFFSET  = 12'd0;
    localparam logic [DIM_W-1:0]    RST_TOP_OFFSET   = 12'd0;

    typedef struct packed {
        logic [DIM_W-1:0]    panel_width;
        logic [DIM_W-1:0]    panel_height;
        logic [STRIDE_W-1:0] line_stride;
        logic                wide_pixels;
        logic [SCALE_W-1:0]  scale_factor;
        logic [DIM_W-1:0]    left_offset;
        logic [DIM_W-1:0]    top_offset;
    } cfg_t;

    // One source pixel after block placement and clipping.
    typedef struct packed {
        logic [BASE_W-1:0] base_x;
        logic [BASE_W-1:0] base_y;
        logic [CNT_W-1:0]  ncols_m1;
        logic [CNT_W-1:0]  nrows_m1;
        logic [DATA_W-1:0] data;
    } job_t;

    // One framebuffer write before address arithmetic.
    typedef struct packed {
        logic [DIM_W-1:0]  fx;
        logic [DIM_W-1:0]  fy;
        logic [DATA_W-1:0] data;
        logic              last;
    } wr_t;

endpackage

`default_nettype wire

[sv/integer_upscale_pixel_writer.sv]
// Path: an item passes the placement, clipping, sequencer, multiply and output registers in turn.
// Throughput: one write per cycle while out_stall is low; an item with n visible writes holds the
// sequencer for n writes, so up to 64 writes at scale 8, and an item with no visible writes is
// dropped at its input. The sequencer walks a block one write at a time and sets the rate.
// Reset (rst_n low, asynchronous) empties every stage and loads the register reset values.
// ============================================================================
// integer_upscale_pixel_writer - nearest-neighbor integer scaler, pixel writer
// Expands each source pixel into the framebuffer writes of its scaled block.
// ============================================================================
`default_nettype none

module integer_upscale_pixel_writer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ius_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    // Source pixel channel.
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [ius_pkg::COL_W-1:0]       src_column,
    input  wire logic [ius_pkg::ROW_W-1:0]       src_row,
    input  wire logic [ius_pkg::COLOR_W-1:0]     pixel_color,
    // Framebuffer write channel.
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [ius_pkg::OFFSET_W-1:0]         byte_offset,
    output logic [ius_pkg::DATA_W-1:0]           pixel_data,
    output logic                                 last_write
);
    import ius_pkg::*;

    // The pipeline runs in five register stages:
    //   stage 0  places the block on the panel (column and row times the scale plus the
    //            offsets) and formats the color, packing it to RGB565 in 16 bpp mode;
    //   stage 1  clips the block against the panel size. Because the block starts at its
    //            top left corner, the visible writes always form a prefix of lines and of
    //            columns, so two counts describe them fully. A source pixel outside the
    //            picture or a block entirely off the panel becomes an empty job;
    //   stage 2  the sequencer steps through the visible lines and columns, one write per
    //            cycle while the output is not stalled, and marks the final one. Empty jobs
    //            are dropped here and never occupy the sequencer, so they never produce a write;
    //   stage 3  multiplies the line by the stride and scales the column by the pixel size;
    //   stage 4  adds both into the output register.
    // Each stage takes new data whenever it is empty or its content moves on, so bubbles
    // close up and a stalled output holds its item while earlier stages keep filling.

    cfg_t  cfg;
    logic  job_valid, job_empty, job_ready;
    job_t  job;
    logic  wr_valid, wr_ready;
    wr_t   wr;

    ius_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ius_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .src_column  (src_column),
        .src_row     (src_row),
        .pixel_color (pixel_color),
        .job_valid   (job_valid),
        .job_empty   (job_empty),
        .job         (job),
        .job_ready   (job_ready)
    );

    ius_gen u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_empty (job_empty),
        .job       (job),
        .job_ready (job_ready),
        .wr_valid  (wr_valid),
        .wr        (wr),
        .wr_ready  (wr_ready)
    );

    ius_addr u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .wr_valid    (wr_valid),
        .wr          (wr),
        .wr_ready    (wr_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_offset (byte_offset),
        .pixel_data  (pixel_data),
        .last_write  (last_write)
    );

endmodule

`default_nettype wire

[sv/ius_regs.sv]
// ============================================================================
// ius_regs - configuration register file
// APB-style slave with zero wait states holding the seven control registers.
// ============================================================================
`default_nettype none

module ius_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ius_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    output ius_pkg::cfg_t                        cfg
);
    import ius_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PANEL_WIDTH:  cfg_next.panel_width  = pwdata[DIM_W-1:0];
                REG_PANEL_HEIGHT: cfg_next.panel_height = pwdata[DIM_W-1:0];
                REG_LINE_STRIDE:  cfg_next.line_stride  = pwdata[STRIDE_W-1:0];
                REG_WIDE_PIXELS:  cfg_next.wide_pixels  = pwdata[0];
                REG_SCALE_FACTOR: cfg_next.scale_factor = pwdata[SCALE_W-1:0];
                REG_LEFT_OFFSET:  cfg_next.left_offset  = pwdata[DIM_W-1:0];
                REG_TOP_OFFSET:   cfg_next.top_offset   = pwdata[DIM_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width  <= RST_PANEL_WIDTH;
            cfg_reg.panel_height <= RST_PANEL_HEIGHT;
            cfg_reg.line_stride  <= RST_LINE_STRIDE;
            cfg_reg.wide_pixels  <= RST_WIDE_PIXELS;
            cfg_reg.scale_factor <= RST_SCALE_FACTOR;
            cfg_reg.left_offset  <= RST_LEFT_OFFSET;
            cfg_reg.top_offset   <= RST_TOP_OFFSET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PANEL_WIDTH:  prdata = 32'(cfg_reg.panel_width);
            REG_PANEL_HEIGHT: prdata = 32'(cfg_reg.panel_height);
            REG_LINE_STRIDE:  prdata = 32'(cfg_reg.line_stride);
            REG_WIDE_PIXELS:  prdata = 32'(cfg_reg.wide_pixels);
            REG_SCALE_FACTOR: prdata = 32'(cfg_reg.scale_factor);
            REG_LEFT_OFFSET:  prdata = 32'(cfg_reg.left_offset);
            REG_TOP_OFFSET:   prdata = 32'(cfg_reg.top_offset);
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[sv/ius_prep.sv]
// ============================================================================
// ius_prep - block placement and clipping stages
// Stage 0 places the scaled block and formats the color; stage 1 clips the
// block against the panel and counts the visible columns and lines.
// ============================================================================
`default_nettype none

module ius_prep (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ius_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ius_pkg::COL_W-1:0]     src_column,
    input  wire logic [ius_pkg::ROW_W-1:0]     src_row,
    input  wire logic [ius_pkg::COLOR_W-1:0]   pixel_color,
    output logic                               job_valid,
    output logic                               job_empty,
    output ius_pkg::job_t                      job,
    input  wire logic                          job_ready
);
    import ius_pkg::*;

    function automatic logic [DATA_W-1:0] pack565(input logic [COLOR_W-1:0] c);
        logic [15:0] p;
        p = (c[23:8] & MASK_RED) | (c[20:5] & MASK_GREEN) | (c[18:3] & MASK_BLUE);
        return {16'h0000, p};
    endfunction

    // Stage 0
    logic              s0_valid_reg, s0_valid_next;
    logic              s0_in_pic_reg;
    logic [BASE_W-1:0] s0_base_x_reg, s0_base_y_reg;
    logic [NUM_W-1:0]  s0_scale_reg;
    logic [DATA_W-1:0] s0_data_reg;

    // Stage 1
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_empty_reg;
    job_t              s1_job_reg;

    logic              s0_open, s1_open;
    logic [NUM_W-1:0]  scale;
    logic              in_pic;
    logic [BASE_W-1:0] base_x, base_y;
    logic [BASE_W-1:0] diff_x, diff_y;
    logic [NUM_W-1:0]  ncols, nrows;
    job_t              job_new;

    assign s1_open  = !s1_valid_reg || job_ready;
    assign s0_open  = !s0_valid_reg || s1_open;
    assign in_stall = !s0_open;

    // A scale of zero acts as one, anything above the maximum as the maximum.
    always_comb
    begin
        priority if (cfg.scale_factor == '0)
            scale = NUM_W'(1);
        else if (32'(cfg.scale_factor) > 32'(MAX_SCALE))
            scale = NUM_W'(MAX_SCALE);
        else
            scale = NUM_W'(cfg.scale_factor);
    end

    assign in_pic = (32'(src_column) < 32'(SRC_WIDTH)) && (32'(src_row) < 32'(SRC_HEIGHT));
    assign base_x = BASE_W'(cfg.left_offset) + BASE_W'(BASE_W'(src_column) * BASE_W'(scale));
    assign base_y = BASE_W'(cfg.top_offset) + BASE_W'(BASE_W'(src_row) * BASE_W'(scale));

    assign s0_valid_next = s0_open ? in_valid : s0_valid_reg;
    assign s1_valid_next = s1_open ? s0_valid_reg : s1_valid_reg;

    // Visible columns and lines form a prefix of the block.
    assign diff_x = BASE_W'({1'b0, cfg.panel_width}) - s0_base_x_reg;
    assign diff_y = BASE_W'({1'b0, cfg.panel_height}) - s0_base_y_reg;

    always_comb
    begin
        priority if (s0_base_x_reg >= BASE_W'({1'b0, cfg.panel_width}))
            ncols = '0;
        else if (diff_x > BASE_W'(s0_scale_reg))
            ncols = s0_scale_reg;
        else
            ncols = NUM_W'(diff_x);

        priority if (s0_base_y_reg >= BASE_W'({1'b0, cfg.panel_height}))
            nrows = '0;
        else if (diff_y > BASE_W'(s0_scale_reg))
            nrows = s0_scale_reg;
        else
            nrows = NUM_W'(diff_y);
    end

    always_comb
    begin
        job_new.base_x   = s0_base_x_reg;
        job_new.base_y   = s0_base_y_reg;
        job_new.ncols_m1 = CNT_W'(ncols - NUM_W'(1));
        job_new.nrows_m1 = CNT_W'(nrows - NUM_W'(1));
        job_new.data     = s0_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_open)
        begin
            s0_in_pic_reg <= in_pic;
            s0_base_x_reg <= base_x;
            s0_base_y_reg <= base_y;
            s0_scale_reg  <= scale;
            s0_data_reg   <= cfg.wide_pixels ? pixel_color : pack565(pixel_color);
        end
        if (s1_open)
        begin
            s1_empty_reg <= !s0_in_pic_reg || (ncols == '0) || (nrows == '0);
            s1_job_reg   <= job_new;
        end
    end

    assign job_valid = s1_valid_reg;
    assign job_empty = s1_empty_reg;
    assign job       = s1_job_reg;

endmodule

`default_nettype wire

[sv/ius_gen.sv]
// ============================================================================
// ius_gen - write sequencer
// Walks the visible part of one block line by line, one write per cycle
// unless stalled, and marks the final write. Empty jobs are dropped.
// ============================================================================
`default_nettype none

module ius_gen (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire logic          job_empty,
    input  wire ius_pkg::job_t job,
    output logic               job_ready,
    output logic               wr_valid,
    output ius_pkg::wr_t       wr,
    input  wire logic          wr_ready
);
    import ius_pkg::*;

    logic             active_reg, active_next;
    logic [CNT_W-1:0] sx_reg, sx_next;
    logic [CNT_W-1:0] sy_reg, sy_next;
    job_t             job_reg;

    logic col_end, row_end, finishing, load;

    assign col_end   = (sx_reg == job_reg.ncols_m1);
    assign row_end   = (sy_reg == job_reg.nrows_m1);
    assign finishing = active_reg && wr_ready && col_end && row_end;
    assign job_ready = job_empty || !active_reg || finishing;
    assign load      = job_valid && !job_empty && (!active_reg || finishing);

    always_comb
    begin
        active_next = active_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        if (active_reg && wr_ready)
        begin
            if (col_end)
            begin
                sx_next = '0;
                if (row_end)
                    active_next = 1'b0;
                else
                    sy_next = sy_reg + CNT_W'(1);
            end
            else
            begin
                sx_next = sx_reg + CNT_W'(1);
            end
        end
        if (load)
        begin
            active_next = 1'b1;
            sx_next     = '0;
            sy_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sx_reg     <= '0;
            sy_reg     <= '0;
        end
        else
        begin
            active_reg <= active_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job;
    end

    assign wr_valid = active_reg;

    always_comb
    begin
        wr.fx   = DIM_W'(job_reg.base_x + BASE_W'(sx_reg));
        wr.fy   = DIM_W'(job_reg.base_y + BASE_W'(sy_reg));
        wr.data = job_reg.data;
        wr.last = col_end && row_end;
    end

endmodule

`default_nettype wire

[sv/ius_addr.sv]
// ============================================================================
// ius_addr - byte offset stages and output register
// Multiplies the line by the stride, scales the column by the pixel size,
// then adds the two into the output register.
// ============================================================================
`default_nettype none

module ius_addr (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ius_pkg::cfg_t                 cfg,
    input  wire logic                          wr_valid,
    input  wire ius_pkg::wr_t                  wr,
    output logic                               wr_ready,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ius_pkg::OFFSET_W-1:0]       byte_offset,
    output logic [ius_pkg::DATA_W-1:0]         pixel_data,
    output logic                               last_write
);
    import ius_pkg::*;

    logic                m_valid_reg, m_valid_next;
    logic [OFFSET_W-1:0] m_prod_reg;
    logic [XOFF_W-1:0]   m_xoff_reg;
    logic [DATA_W-1:0]   m_data_reg;
    logic                m_last_reg;

    logic                o_valid_reg, o_valid_next;
    logic [OFFSET_W-1:0] o_offset_reg;
    logic [DATA_W-1:0]   o_data_reg;
    logic                o_last_reg;

    logic                m_open, o_open;
    logic [OFFSET_W-1:0] prod;
    logic [XOFF_W-1:0]   xoff;

    assign o_open   = !o_valid_reg || !out_stall;
    assign m_open   = !m_valid_reg || o_open;
    assign wr_ready = m_open;

    assign prod = OFFSET_W'(OFFSET_W'(wr.fy) * OFFSET_W'(cfg.line_stride));
    assign xoff = cfg.wide_pixels ? {wr.fx, 2'b00} : {1'b0, wr.fx, 1'b0};

    assign m_valid_next = m_open ? wr_valid : m_valid_reg;
    assign o_valid_next = o_open ? m_valid_reg : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_open)
        begin
            m_prod_reg <= prod;
            m_xoff_reg <= xoff;
            m_data_reg <= wr.data;
            m_last_reg <= wr.last;
        end
        if (o_open)
        begin
            // The sum wraps modulo the offset width.
            o_offset_reg <= m_prod_reg + OFFSET_W'(m_xoff_reg);
            o_data_reg   <= m_data_reg;
            o_last_reg   <= m_last_reg;
        end
    end

    assign out_valid   = o_valid_reg;
    assign byte_offset = o_offset_reg;
    assign pixel_data  = o_data_reg;
    assign last_write  = o_last_reg;

endmodule

`default_nettype wire

[sv/ius_chk.sv]
// ============================================================================
// ius_chk - port-level checker
// Watches the ports of the pixel writer and checks output stability, the
// narrow pixel format and that no write appears without a pending item.
// ============================================================================
`default_nettype none

module ius_chk (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ius_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    input  wire logic                            pready,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [ius_pkg::OFFSET_W-1:0]    byte_offset,
    input  wire logic [ius_pkg::DATA_W-1:0]      pixel_data,
    input  wire logic                            last_write
);
    import ius_pkg::*;

    localparam int PEND_W = 7;

    logic              wide_reg, wide_next;
    logic [PEND_W-1:0] pending_reg, pending_next;
    logic              cfg_wr, in_acc, out_done;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_acc   = in_valid && !in_stall;
    assign out_done = out_valid && !out_stall && last_write;

    assign wide_next = (cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_WIDE_PIXELS)) ?
                       pwdata[0] : wide_reg;

    // Items accepted but not yet closed by a final write; sticks once saturated.
    always_comb
    begin
        pending_next = pending_reg;
        if (pending_reg != '1)
        begin
            if (in_acc && !out_done)
                pending_next = pending_reg + PEND_W'(1);
            else if (!in_acc && out_done)
                pending_next = pending_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg    <= RST_WIDE_PIXELS;
            pending_reg <= '0;
        end
        else
        begin
            wide_reg    <= wide_next;
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_offset)
            && $stable(pixel_data) && $stable(last_write))
        else $error("stalled write changed");

    a_narrow_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !wide_reg |-> pixel_data[31:16] == 16'h0000)
        else $error("upper half set in 16 bpp mode");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("write without a pending item");

endmodule

bind integer_upscale_pixel_writer ius_chk u_ius_chk (.*);

`default_nettype wire
